@@ rtl/olid_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the ordered list.
package olid_pkg;

    // Default list depth
    localparam int OLID_DEPTH = 64;

    // Field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int ENTRY_W = ROW_W + COL_W + VAL_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // Entry returned by a delete that misses: row -1, col -1, value 0
    localparam logic [ENTRY_W-1:0] ENTRY_FAIL = {{ROW_W{1'b1}}, {COL_W{1'b1}}, {VAL_W{1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic capture;       // latch the incoming request
        logic latch_status;  // latch the evaluated status code
        logic shift_init;    // load shift pointers for insert or delete
        logic shift_step;    // move one entry, read/write pipelined
        logic read_pos;      // read the entry at the request position
        logic write_pos;     // write request data at the request position
        logic hold_load;     // keep the entry just read
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic res_load;      // load the output register
    } olid_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic is_replace;
        logic is_get;
        logic is_clear;
        logic bad_pos;
        logic full;
        logic shift_last;    // no entries left to move
        logic res_free;      // output register empty or being taken
    } olid_stat_t;

endpackage

@@ rtl/olid_ctrl.sv @@
// Command sequencer for the ordered list: evaluate, then fetch, shift, write as a request needs.
module olid_ctrl
    import olid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  olid_stat_t stat,
    output olid_cmd_t  ctl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_FETCH = 6'b000100,
        S_SHIFT = 6'b001000,
        S_PUT   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ok;

    // Request passes its range and capacity checks
    assign ok = !stat.bad_pos && !(stat.is_insert && stat.full);

    assign cmd_ready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.latch_status = 1'b1;
                priority if (stat.is_clear)
                begin
                    ctl.cnt_clr = 1'b1;
                    state_next  = S_DONE;
                end
                else if (!ok)
                begin
                    state_next = S_DONE;
                end
                else if (stat.is_insert)
                begin
                    ctl.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
                else if (stat.is_delete || stat.is_get)
                begin
                    ctl.read_pos = 1'b1;
                    state_next   = S_FETCH;
                end
                else if (stat.is_replace)
                begin
                    ctl.write_pos = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                ctl.hold_load = 1'b1;
                if (stat.is_delete)
                begin
                    ctl.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (stat.shift_last)
                begin
                    if (stat.is_insert)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ctl.cnt_dec = 1'b1;
                        state_next  = S_DONE;
                    end
                end
            end
            S_PUT:
            begin
                ctl.write_pos = 1'b1;
                ctl.cnt_inc   = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (stat.res_free)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/olid_datapath.sv @@
// Entry memory, entry count, shift pointers and output register of the ordered list.
module olid_datapath
    import olid_pkg::*;
#(
    parameter int DEPTH = OLID_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  olid_cmd_t               ctl,
    output olid_stat_t              stat,
    input  logic [CMD_W-1:0]        command,
    input  logic [POS_W-1:0]        position,
    input  logic signed [ROW_W-1:0] entry_row,
    input  logic signed [COL_W-1:0] entry_col,
    input  logic signed [VAL_W-1:0] entry_value,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [STAT_W-1:0]       status,
    output logic signed [ROW_W-1:0] out_row,
    output logic signed [COL_W-1:0] out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic [CNT_W-1:0]        count,
    output logic                    is_empty,
    output logic                    is_full
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Entry storage, no reset: only entries below the count are read
    logic [ENTRY_W-1:0] entry_mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Request registers
    logic [CMD_W-1:0]   op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [ENTRY_W-1:0] data_reg;
    logic [ENTRY_W-1:0] hold_reg;
    logic [STAT_W-1:0]  stat_reg;

    // Control state
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] left_reg;
    logic [AW-1:0] src_reg;
    logic [AW-1:0] wr_addr_reg;
    logic          wr_pend_reg;
    logic          res_valid_reg;

    // Output register
    logic [STAT_W-1:0]  res_stat_reg;
    logic [ENTRY_W-1:0] res_entry_reg;
    logic [CNT_W-1:0]   res_cnt_reg;
    logic               res_empty_reg;
    logic               res_full_reg;

    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic [AW-1:0]      pos_idx;
    logic               op_ins;
    logic               op_del;
    logic               op_rep;
    logic               op_get;
    logic               op_clr;
    logic               pos_gt;
    logic               pos_ge;
    logic               full;
    logic               bad_pos;
    logic [STAT_W-1:0]  eval_status;
    logic               shift_rd;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [ENTRY_W-1:0] mem_wd;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;
    logic [ENTRY_W-1:0] res_entry;

    // Opcode decode
    assign op_ins = (op_reg == CMD_INSERT);
    assign op_del = (op_reg == CMD_DELETE);
    assign op_rep = (op_reg == CMD_REPLACE);
    assign op_get = (op_reg == CMD_GET);
    assign op_clr = (op_reg == CMD_CLEAR);

    // Position checks
    assign pos_ext = CMPW'(pos_reg);
    assign cnt_ext = CMPW'(cnt_reg);
    assign pos_idx = AW'(pos_ext);
    assign pos_gt  = (pos_ext > cnt_ext);
    assign pos_ge  = (pos_ext >= cnt_ext);
    assign full    = (cnt_reg == CW'(DEPTH));
    assign bad_pos = op_ins ? pos_gt : ((op_del || op_rep || op_get) && pos_ge);

    always_comb
    begin
        priority if (bad_pos)
        begin
            eval_status = ST_BADPOS;
        end
        else if (op_ins && full)
        begin
            eval_status = ST_FULL;
        end
        else
        begin
            eval_status = ST_OK;
        end
    end

    assign stat.is_insert  = op_ins;
    assign stat.is_delete  = op_del;
    assign stat.is_replace = op_rep;
    assign stat.is_get     = op_get;
    assign stat.is_clear   = op_clr;
    assign stat.bad_pos    = bad_pos;
    assign stat.full       = full;
    assign stat.shift_last = (left_reg == '0);
    assign stat.res_free   = !res_valid_reg || res_ready;

    // Memory port selection: shift moves one entry per cycle, read then write
    assign shift_rd = ctl.shift_step && (left_reg != '0);
    assign mem_re   = ctl.read_pos || shift_rd;
    assign mem_ra   = ctl.read_pos ? pos_idx : src_reg;
    assign mem_we   = ctl.write_pos || (ctl.shift_step && wr_pend_reg);
    assign mem_wa   = ctl.write_pos ? pos_idx : wr_addr_reg;
    assign mem_wd   = ctl.write_pos ? data_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[mem_ra];
        end
    end

    // Request, hold and status capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= command;
            pos_reg  <= position;
            data_reg <= {entry_row, entry_col, entry_value};
        end
        if (ctl.hold_load)
        begin
            hold_reg <= rd_data_reg;
        end
        if (ctl.latch_status)
        begin
            stat_reg <= eval_status;
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        else if (ctl.cnt_dec)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // Shift pointers: insert walks down from the top, delete walks up from position + 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg    <= '0;
            src_reg     <= '0;
            wr_addr_reg <= '0;
            wr_pend_reg <= 1'b0;
        end
        else if (ctl.shift_init)
        begin
            wr_pend_reg <= 1'b0;
            if (op_ins)
            begin
                left_reg <= CW'(cnt_ext - pos_ext);
                src_reg  <= AW'(cnt_ext - CMPW'(1));
            end
            else
            begin
                left_reg <= CW'(cnt_ext - pos_ext - CMPW'(1));
                src_reg  <= AW'(pos_ext + CMPW'(1));
            end
        end
        else if (ctl.shift_step)
        begin
            wr_pend_reg <= shift_rd;
            if (shift_rd)
            begin
                left_reg <= left_reg - CW'(1);
                if (op_ins)
                begin
                    wr_addr_reg <= src_reg + AW'(1);
                    src_reg     <= src_reg - AW'(1);
                end
                else
                begin
                    wr_addr_reg <= src_reg - AW'(1);
                    src_reg     <= src_reg + AW'(1);
                end
            end
        end
    end

    // Result entry selection
    always_comb
    begin
        priority if (op_del && (stat_reg != ST_OK))
        begin
            res_entry = ENTRY_FAIL;
        end
        else if ((op_del || op_get) && (stat_reg == ST_OK))
        begin
            res_entry = hold_reg;
        end
        else
        begin
            res_entry = '0;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (ctl.res_load)
        begin
            res_stat_reg  <= stat_reg;
            res_entry_reg <= res_entry;
            res_cnt_reg   <= CNT_W'(cnt_reg);
            res_empty_reg <= (cnt_reg == '0);
            res_full_reg  <= full;
        end
    end

    assign res_valid = res_valid_reg;
    assign status    = res_stat_reg;
    assign out_row   = res_entry_reg[ENTRY_W-1 -: ROW_W];
    assign out_col   = res_entry_reg[VAL_W +: COL_W];
    assign out_value = res_entry_reg[VAL_W-1:0];
    assign count     = res_cnt_reg;
    assign is_empty  = res_empty_reg;
    assign is_full   = res_full_reg;

endmodule

@@ rtl/ordered_list_insert_delete.sv @@
// Ordered list of (row, column, value) entries: top level joining sequencer and datapath.
//
// The block holds up to DEPTH entries in one memory with a registered read port and
// one write port, plus an entry count that reset or a clear request empties; there is
// no clearing pass. One request is worked on at a time; the next is taken once the
// current one has moved into the output register, which can hold a result while the
// next request runs. Insert and delete move one entry per cycle through the memory,
// reading the next entry while writing the previous one, so their time follows the
// number of entries from the position upward. count reports the entry count in 7 bits.
module ordered_list_insert_delete
    import olid_pkg::*;
#(
    parameter int DEPTH = OLID_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  logic [CMD_W-1:0]        command,
    input  logic [POS_W-1:0]        position,
    input  logic signed [ROW_W-1:0] entry_row,
    input  logic signed [COL_W-1:0] entry_col,
    input  logic signed [VAL_W-1:0] entry_value,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [STAT_W-1:0]       status,
    output logic signed [ROW_W-1:0] out_row,
    output logic signed [COL_W-1:0] out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic [CNT_W-1:0]        count,
    output logic                    is_empty,
    output logic                    is_full
);

    olid_cmd_t  ctl;
    olid_stat_t stat;

    // Request sequencer
    olid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Storage and result path
    olid_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .position    (position),
        .entry_row   (entry_row),
        .entry_col   (entry_col),
        .entry_value (entry_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .status      (status),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .count       (count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule
